@@ sv/assert_macros.svh @@
// Assertion helpers. Each use names its own clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/nps_pkg.sv @@
package nps_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_SHADES          = 64;

  localparam logic [6:0] SHADE_COUNT_RESET = 7'd32;

  // item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_BLEND = 2'd1;
  localparam logic [1:0] MODE_TINT  = 2'd2;
  localparam logic [1:0] MODE_SHADE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SHADE_COUNT = 2'd0;
  localparam logic [1:0] CFG_TINT_RED    = 2'd1;
  localparam logic [1:0] CFG_TINT_GREEN  = 2'd2;
  localparam logic [1:0] CFG_TINT_BLUE   = 2'd3;

  // luminance weights, red / green / blue
  localparam logic [9:0] LUMA_W [3] = '{10'd299, 10'd587, 10'd114};

  typedef struct packed {
    logic wr;          // palette write from an accepted item
    logic load;        // capture a search item
    logic rd_a;        // read first source entry
    logic rd_b;        // read second source entry
    logic cap_a;       // hold first source color
    logic set_target;  // form the target from the source read
    logic scan_valid;  // sweep address is live
    logic scan_last;   // sweep address is the last entry
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_cmp;    // last entry compared this cycle
  } dp_status_t;

endpackage

@@ sv/nps_ctrl.sv @@
`include "assert_macros.svh"

module nps_ctrl #(
  parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(PALETTE_ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             mode,
  output logic                   busy,
  output logic                   done,
  output nps_pkg::ctrl_cmd_t     cmd,
  output logic [IDX_W-1:0]       scan_addr,
  input  nps_pkg::dp_status_t    status
);
  import nps_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RD_A   = 7'b0000010,
    ST_RD_B   = 7'b0000100,
    ST_SETUP  = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [1:0]       mode_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      mode_q <= MODE_WRITE;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (start && !busy) begin
        mode_q <= mode;
      end
    end
  end

  assign busy      = (state != ST_IDLE);
  assign scan_addr = cnt;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = (mode_q == MODE_BLEND) ? ST_RD_B : ST_SETUP;
      end
      ST_RD_B: begin
        cmd.rd_b   = 1'b1;
        cmd.cap_a  = 1'b1;
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.set_target = 1'b1;
        cnt_next       = '0;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_valid = 1'b1;
        cmd.scan_last  = (cnt == LAST_IDX);
        if (cnt == LAST_IDX) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status.last_cmp) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLY(a_cmp_in_drain, clk, rst, status.last_cmp, state == ST_DRAIN)
  `ASSERT_NEXT(a_search_busy, clk, rst, start && !busy && mode != MODE_WRITE, busy)
  `ASSERT_NEXT(a_write_idle, clk, rst, start && !busy && mode == MODE_WRITE, !busy)
  `ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)

endmodule

@@ sv/nps_datapath.sv @@
module nps_datapath #(
  parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(PALETTE_ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nps_pkg::ctrl_cmd_t     cmd,
  input  logic [IDX_W-1:0]       scan_addr,
  output nps_pkg::dp_status_t    status,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [6:0]             cfg_data,
  input  logic [1:0]             mode,
  input  logic [7:0]             entry_index,
  input  logic [7:0]             second_index,
  input  logic [5:0]             shade_level,
  input  logic [5:0]             red,
  input  logic [5:0]             green,
  input  logic [5:0]             blue,
  output logic [7:0]             nearest_entry
);
  import nps_pkg::*;

  function automatic logic in_range(input logic [7:0] idx);
    return {1'b0, idx} < 9'(PALETTE_ENTRIES);
  endfunction

  // configuration
  logic [6:0] shade_count;
  logic [5:0] tint_q [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_count <= SHADE_COUNT_RESET;
      tint_q[0]   <= '0;
      tint_q[1]   <= '0;
      tint_q[2]   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHADE_COUNT: shade_count <= cfg_data;
        CFG_TINT_RED:    tint_q[0]   <= cfg_data[5:0];
        CFG_TINT_GREEN:  tint_q[1]   <= cfg_data[5:0];
        CFG_TINT_BLUE:   tint_q[2]   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // item capture; shade count and level clamped here
  logic [6:0] s_cl, s_m1, lvl7, lvl_c, f7;
  logic       dark;

  always_comb begin
    if (shade_count == 7'd0) begin
      s_cl = 7'd1;
    end else if (shade_count > 7'(MAX_SHADES)) begin
      s_cl = 7'(MAX_SHADES);
    end else begin
      s_cl = shade_count;
    end
    s_m1  = s_cl - 7'd1;
    lvl7  = {1'b0, shade_level};
    lvl_c = (lvl7 > s_m1) ? s_m1 : lvl7;
    dark  = (lvl_c == s_m1);
    f7    = s_m1 - lvl_c;
  end

  logic [1:0] mode_q;
  logic [7:0] ea_q, eb_q;
  logic [5:0] k_q, f_q;
  logic       luma_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      ea_q   <= entry_index;
      eb_q   <= second_index;
      f_q    <= f7[5:0];
      if (mode == MODE_SHADE) begin
        k_q    <= s_m1[5:0];
        luma_q <= dark;
      end else begin
        k_q    <= 6'd2;
        luma_q <= 1'b0;
      end
    end
  end

  // palette memory, one write and one registered read port
  logic [17:0]      mem [PALETTE_ENTRIES];
  logic [17:0]      rd_data;
  logic             rd_oob;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    if (cmd.rd_a) begin
      rd_addr = ea_q[IDX_W-1:0];
    end else if (cmd.rd_b) begin
      rd_addr = eb_q[IDX_W-1:0];
    end else begin
      rd_addr = scan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && in_range(entry_index)) begin
      mem[entry_index[IDX_W-1:0]] <= {red, green, blue};
    end
    rd_data <= mem[rd_addr];
    rd_oob  <= (cmd.rd_a && !in_range(ea_q)) || (cmd.rd_b && !in_range(eb_q));
  end

  // source color: out-of-range index reads as black
  logic [5:0] src_c [3];
  logic [5:0] a_q   [3];
  logic [11:0] t_q  [3];
  logic [11:0] t_new [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      src_c[j] = rd_oob ? 6'd0 : rd_data[6*(2-j) +: 6];
      case (mode_q)
        MODE_BLEND: t_new[j] = 12'(a_q[j]) + 12'(src_c[j]);
        MODE_TINT:  t_new[j] = 12'(src_c[j]) + 12'(tint_q[j]);
        default:    t_new[j] = 12'(src_c[j]) * 12'(f_q);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (cmd.cap_a) begin
        a_q[j] <= src_c[j];
      end
      if (cmd.set_target) begin
        t_q[j] <= t_new[j];
      end
    end
  end

  // sweep pipeline: read, error, square, sum, compare
  logic             v1, v2, v3, v4;
  logic             last1, last2, last3, last4;
  logic [IDX_W-1:0] idx1, idx2, idx3, idx4;
  logic signed [13:0] e2    [3];
  logic signed [13:0] e_new [3];
  logic [23:0]        term3    [3];
  logic [23:0]        term_new [3];
  logic [25:0]        d4;
  logic [IDX_W-1:0]   best;
  logic [25:0]        best_d;

  always_comb begin
    logic [11:0]        ck;
    logic signed [27:0] sq;
    logic [15:0]        lw;
    for (int j = 0; j < 3; j++) begin
      ck = 12'(rd_data[6*(2-j) +: 6]) * 12'(k_q);
      if (luma_q) begin
        e_new[j] = $signed({8'd0, rd_data[6*(2-j) +: 6]});
      end else begin
        e_new[j] = $signed({2'b00, ck}) - $signed({2'b00, t_q[j]});
      end
    end
    for (int j = 0; j < 3; j++) begin
      sq = e2[j] * e2[j];
      lw = 16'(e2[j][5:0]) * 16'(LUMA_W[j]);
      term_new[j] = luma_q ? 24'(lw) : sq[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    last1 <= cmd.scan_last;
    last2 <= last1;
    last3 <= last2;
    last4 <= last3;
    idx1  <= scan_addr;
    idx2  <= idx1;
    idx3  <= idx2;
    idx4  <= idx3;
    e2    <= e_new;
    term3 <= term_new;
    d4    <= 26'(term3[0]) + 26'(term3[1]) + 26'(term3[2]);
    // strict compare keeps the lowest index on ties
    if (v4 && (idx4 == '0 || d4 < best_d)) begin
      best   <= idx4;
      best_d <= d4;
    end
  end

  assign status.last_cmp = v4 && last4;
  assign nearest_entry   = 8'(best);

endmodule

@@ sv/nearest_palette_color_search.sv @@
// channel   direction  handshake                     payload
// item      in         start & !busy                 mode, entry_index, second_index,
//                                                    shade_level, red, green, blue
// result    out        done, one cycle               nearest_entry
// config    in         cfg_valid & cfg_ready         cfg_index, cfg_data
//
// A write item (mode 0) is taken while idle; busy stays low.
// A search item keeps busy high while the source entry is read (both entries for a blend),
// the target is set and the palette memory is swept, one entry per cycle on its read port.
// done pulses for one cycle with nearest_entry; the receiver cannot stall it.
// Synchronous reset sets shade_count to 32 and the tint to black; palette
// contents stay undefined until written. cfg_ready is always high.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [7:0] entry_index,
  input  logic [7:0] second_index,
  input  logic [5:0] shade_level,
  input  logic [5:0] red,
  input  logic [5:0] green,
  input  logic [5:0] blue,
  output logic       done,
  output logic [7:0] nearest_entry,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import nps_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] scan_addr;

  assign cfg_ready = 1'b1;

  nps_ctrl #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .scan_addr (scan_addr),
    .status    (status)
  );

  nps_datapath #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .scan_addr     (scan_addr),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .entry_index   (entry_index),
    .second_index  (second_index),
    .shade_level   (shade_level),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .nearest_entry (nearest_entry)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import nps_pkg::*;

  localparam int PAL_SIZE        = PALETTE_ENTRIES_DEF;
  localparam int SETTLE_CYCLES   = PAL_SIZE + 16;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 172;
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int LUMA_R          = 299;
  localparam int LUMA_G          = 587;
  localparam int LUMA_B          = 114;

  typedef struct packed {
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
  } rgb_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] ea;
    logic [7:0] eb;
    logic [5:0] lvl;
    rgb_t       color;
  } paint_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] mode = MODE_WRITE;
  logic [7:0] entry_index = '0;
  logic [7:0] second_index = '0;
  logic [5:0] shade_level = '0;
  logic [5:0] red = '0;
  logic [5:0] green = '0;
  logic [5:0] blue = '0;
  logic       done;
  logic [7:0] nearest_entry;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_SHADE_COUNT;
  logic [6:0] cfg_data = '0;

  nearest_palette_color_search dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .entry_index(entry_index),
    .second_index(second_index),
    .shade_level(shade_level),
    .red(red),
    .green(green),
    .blue(blue),
    .done(done),
    .nearest_entry(nearest_entry),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // palette and register copies kept by the predictor
  rgb_t        pal_copy [PAL_SIZE];
  logic [6:0]  shade_cfg = SHADE_COUNT_RESET;
  rgb_t        tint_cfg = '0;

  paint_item_t pending_items [$];
  logic [7:0]  nearest_due [$];
  paint_item_t cur_item = '0;
  int          idle_left = 0;
  bit          gaps_on = 1'b1;
  int          mismatches = 0;
  int unsigned cycles = 0;
  logic [7:0]  want_entry;
  logic [6:0]  shade_plan [PHASES] = '{7'd32, 7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd45};

  function automatic int clamp_shades(input int v);
    if (v < 1) return 1;
    if (v > MAX_SHADES) return MAX_SHADES;
    return v;
  endfunction

  // target held as numerators over denominator k; lowest index wins ties
  function automatic logic [7:0] closest_entry(input int tr, input int tg, input int tbl,
                                               input int k);
    logic [7:0] best;
    longint     best_d;
    longint     d;
    longint     er;
    longint     eg;
    longint     eb;
    best = '0;
    best_d = 0;
    for (int i = 0; i < PAL_SIZE; i++) begin
      er = longint'(pal_copy[i].r) * k - tr;
      eg = longint'(pal_copy[i].g) * k - tg;
      eb = longint'(pal_copy[i].b) * k - tbl;
      d = er * er + eg * eg + eb * eb;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = 8'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [7:0] dimmest_entry();
    logic [7:0] best;
    int         best_l;
    int         l;
    best = '0;
    best_l = 0;
    for (int i = 0; i < PAL_SIZE; i++) begin
      l = int'(pal_copy[i].r) * LUMA_R + int'(pal_copy[i].g) * LUMA_G
          + int'(pal_copy[i].b) * LUMA_B;
      if (i == 0 || l < best_l) begin
        best_l = l;
        best = 8'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [7:0] nearest_for(input paint_item_t it);
    int ar;
    int ag;
    int ab;
    int s;
    int lvl;
    int f;
    ar = int'(pal_copy[it.ea].r);
    ag = int'(pal_copy[it.ea].g);
    ab = int'(pal_copy[it.ea].b);
    case (it.mode)
      MODE_BLEND: begin
        return closest_entry(ar + int'(pal_copy[it.eb].r), ag + int'(pal_copy[it.eb].g),
                             ab + int'(pal_copy[it.eb].b), 2);
      end
      MODE_TINT: begin
        return closest_entry(ar + int'(tint_cfg.r), ag + int'(tint_cfg.g),
                             ab + int'(tint_cfg.b), 2);
      end
      default: begin
        s = clamp_shades(int'(shade_cfg));
        lvl = int'(it.lvl);
        if (lvl > s - 1) lvl = s - 1;
        if (lvl == s - 1) return dimmest_entry();
        f = s - 1 - lvl;
        return closest_entry(ar * f, ag * f, ab * f, s - 1);
      end
    endcase
  endfunction

  function automatic paint_item_t make_item(input logic [1:0] m, input int ea, input int eb,
                                            input int lvl, input int r, input int g,
                                            input int b);
    paint_item_t it;
    it.mode = m;
    it.ea = 8'(ea);
    it.eb = 8'(eb);
    it.lvl = 6'(lvl);
    it.color.r = 6'(r);
    it.color.g = 6'(g);
    it.color.b = 6'(b);
    return it;
  endfunction

  function automatic void add_item(input paint_item_t it);
    pending_items = {pending_items, it};
  endfunction

  // coarse colors give many equal distances, so ties get exercised
  function automatic rgb_t random_color();
    rgb_t c;
    if ($urandom_range(0, 9) < 4) begin
      c.r = 6'(21 * $urandom_range(0, 3));
      c.g = 6'(21 * $urandom_range(0, 3));
      c.b = 6'(21 * $urandom_range(0, 3));
    end else begin
      c = rgb_t'(18'($urandom_range(0, 262143)));
    end
    return c;
  endfunction

  function automatic paint_item_t random_item(input int s_eff);
    paint_item_t it;
    int          pick;
    int          lvl;
    pick = $urandom_range(0, 99);
    it.mode = (pick < 25) ? MODE_WRITE : (pick < 50) ? MODE_BLEND :
              (pick < 70) ? MODE_TINT : MODE_SHADE;
    it.ea = 8'($urandom_range(0, 255));
    it.eb = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      lvl = s_eff - 3 + $urandom_range(0, 4);
      if (lvl < 0) lvl = 0;
      if (lvl > 63) lvl = 63;
    end else begin
      lvl = $urandom_range(0, 63);
    end
    it.lvl = 6'(lvl);
    it.color = random_color();
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [6:0] pick_tint(input int ph);
    if (ph == 1) return 7'h7F;
    if (ph == 2) return 7'h00;
    return 7'($urandom_range(0, 127));
  endfunction

  // item driver; the prediction is made at the edge that accepts the item
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        if (cur_item.mode == MODE_WRITE) pal_copy[cur_item.ea] = cur_item.color;
        else nearest_due = {nearest_due, nearest_for(cur_item)};
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          mode <= cur_item.mode;
          entry_index <= cur_item.ea;
          second_index <= cur_item.eb;
          shade_level <= cur_item.lvl;
          red <= cur_item.color.r;
          green <= cur_item.color.g;
          blue <= cur_item.color.b;
          start <= 1'b1;
          idle_left = gaps_on ? pick_gap() : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (nearest_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: nearest_entry=%0d", nearest_entry);
      end else begin
        want_entry = nearest_due.pop_front();
        if (nearest_entry !== want_entry) begin
          mismatches++;
          if (mismatches <= 10)
            $display("nearest_entry mismatch: expected %0d, got %0d", want_entry,
                     nearest_entry);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SHADE_COUNT: shade_cfg = data;
      CFG_TINT_RED:    tint_cfg.r = data[5:0];
      CFG_TINT_GREEN:  tint_cfg.g = data[5:0];
      default:         tint_cfg.b = data[5:0];
    endcase
  endtask

  // checked at the falling edge so the driver's updates have settled
  task automatic wait_until_quiet();
    @(negedge clk);
    while (pending_items.size() != 0 || start || nearest_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    shade_plan[PHASES-1] = 7'($urandom_range(3, 63));

    // every entry is written before the first search
    for (int i = 0; i < PAL_SIZE; i++) begin
      add_item(make_item(MODE_WRITE, i, $urandom_range(0, 255), 0, 0, 0, 0));
      pending_items[$].color = random_color();
    end

    // extremes, equal colors and tie cases
    add_item(make_item(MODE_WRITE, 0, 255, 63, 63, 63, 63));
    add_item(make_item(MODE_WRITE, 255, 0, 0, 0, 0, 0));
    add_item(make_item(MODE_WRITE, 128, 0, 0, 0, 0, 0));
    add_item(make_item(MODE_WRITE, 17, 0, 0, 21, 42, 0));
    add_item(make_item(MODE_WRITE, 200, 0, 0, 21, 42, 0));
    add_item(make_item(MODE_WRITE, 3, 0, 0, 63, 0, 0));
    add_item(make_item(MODE_WRITE, 4, 0, 0, 0, 63, 0));
    add_item(make_item(MODE_WRITE, 6, 0, 0, 0, 0, 63));
    add_item(make_item(MODE_BLEND, 200, 200, 0, 0, 0, 0));
    add_item(make_item(MODE_BLEND, 0, 255, 63, 63, 63, 63));
    add_item(make_item(MODE_BLEND, 3, 4, 0, 0, 0, 0));
    add_item(make_item(MODE_TINT, 6, 0, 0, 0, 0, 0));
    add_item(make_item(MODE_TINT, 255, 0, 0, 0, 0, 0));
    add_item(make_item(MODE_SHADE, 0, 0, 0, 0, 0, 0));
    add_item(make_item(MODE_SHADE, 0, 0, 1, 0, 0, 0));
    add_item(make_item(MODE_SHADE, 17, 0, 30, 0, 0, 0));
    add_item(make_item(MODE_SHADE, 17, 0, 31, 0, 0, 0));
    add_item(make_item(MODE_SHADE, 3, 0, 63, 0, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_until_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_SHADE_COUNT, shade_plan[ph]);
        write_reg(CFG_TINT_RED, pick_tint(ph));
        write_reg(CFG_TINT_GREEN, pick_tint(ph));
        write_reg(CFG_TINT_BLUE, pick_tint(ph));
        cfg_valid <= 1'b0;
        @(negedge clk);
        gaps_on = (ph % 2 == 0);
      end
      repeat (ITEMS_PER_PHASE)
        add_item(random_item(clamp_shades(int'(shade_cfg))));
      if (ph == 0) begin
        repeat (10) @(posedge clk);
        rst <= 1'b0;
      end
    end

    wait_until_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
